@@ design/sms_pkg.sv @@
`timescale 1ns / 1ps
package sms_pkg;

   localparam int CAPACITY = 64;
   localparam int MAX_DIM  = 16;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DIM_W  = 5;
   localparam int VAL_W  = 32;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int CELL_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int TOT_W  = 2 * DIM_W + 2;

   localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SET_DEF   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TRANSPOSE = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_OOR  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   typedef struct packed {
      logic [DIM_W-1:0]        row;
      logic [DIM_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ design/sms_if.sv @@
`timescale 1ns / 1ps
interface sms_req_if;
   import sms_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic [DIM_W-1:0]        row;
   logic [DIM_W-1:0]        col;
   logic signed [VAL_W-1:0] value;
   modport source (output valid, cmd, row, col, value, input ready);
   modport sink (input valid, cmd, row, col, value, output ready);
endinterface

interface sms_rsp_if;
   import sms_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] read_value;
   logic [STAT_W-1:0]       status;
   logic [CNT_W-1:0]        stored_count;
   modport source (output valid, read_value, status, stored_count, input ready);
   modport sink (input valid, read_value, status, stored_count, output ready);
endinterface

@@ design/sms_ram.sv @@
`timescale 1ns / 1ps
module sms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/sparse_matrix_store.sv @@
`timescale 1ns / 1ps
// Sparse matrix store: keeps (row, column, value) entries in a 64-slot table for cells that
// differ from a default value and answers every command with exactly one item. Commands are
// taken one at a time; req ready is high only while the block is idle. After reset the block
// first clears its cell-mark memory, one cell per cycle, over all MAX_DIM * MAX_DIM (256)
// cells with req ready low. A write or read with an out-of-range index, and a default change
// to the current default, is offered on the cycle after it is taken. Any other write or read,
// and a transpose, walks the slot table once through the single read port of the entry
// memory, one slot per cycle, and then answers. Otherwise a default change spends one table
// walk deciding; if no entry holds the new default, the default simply changes, and if the
// result would exceed CAPACITY it answers table full. Else a second walk deletes in-range
// entries equal to the new default and marks occupied cells, and a fill sequencer then visits
// every in-range cell (up to MAX_DIM * MAX_DIM), reading its mark and then acting on it, and
// stores each unmarked cell in the next free slot, stepping past occupied ones. The entry
// memory needs no clearing: per-slot valid bits mark live entries. The fill clears each cell
// mark as it passes, so the mark memory is empty again at the end of every command.
module sparse_matrix_store (
   input  logic                           clock,
   input  logic                           reset,
   sms_req_if.sink                        req_ch,
   sms_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [sms_pkg::DIM_W-1:0]      csr_wr_data
);
   import sms_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_FILL  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]           op_ff, op_in;
   logic                       pass_b_ff, pass_b_in;
   logic [DIM_W-1:0]           r_ff, r_in, c_ff, c_in;
   logic signed [VAL_W-1:0]    v_ff, v_in;

   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic                       eval_vld_ff, eval_vld_in;
   logic [SLOT_W-1:0]          eval_idx_ff, eval_idx_in;

   logic [CAPACITY-1:0]        valid_ff, valid_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic signed [VAL_W-1:0]    default_ff, default_in;
   logic                       swapped_ff, swapped_in;
   logic [DIM_W-1:0]           row_count_ff, row_count_in;
   logic [DIM_W-1:0]           col_count_ff, col_count_in;

   logic                       hit_ff, hit_in;
   logic [SLOT_W-1:0]          hit_idx_ff, hit_idx_in;
   logic signed [VAL_W-1:0]    hit_val_ff, hit_val_in;
   logic                       free_ff, free_in;
   logic [SLOT_W-1:0]          free_idx_ff, free_idx_in;
   logic                       any_ff, any_in;
   logic [CNT_W-1:0]           present_ff, present_in;
   logic [CNT_W-1:0]           dels_ff, dels_in;

   logic [DIM_W-1:0]           ci_ff, ci_in, cj_ff, cj_in;
   logic [CNT_W-1:0]           fp_ff, fp_in;
   logic                       fphase_ff, fphase_in;
   logic [CELL_W-1:0]          clr_ff, clr_in;

   logic signed [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0]          rsp_status_ff, rsp_status_in;

   // entry memory ports
   logic                       ram_wr_en;
   logic [SLOT_W-1:0]          ram_wr_addr;
   entry_type                  ram_wr_data;
   logic [SLOT_W-1:0]          ram_rd_addr;
   logic [ENTRY_W-1:0]         ram_rd_raw;
   entry_type                  e_entry;

   // cell mark memory ports
   logic                       seen_wr_en;
   logic [CELL_W-1:0]          seen_wr_addr;
   logic                       seen_wr_data;
   logic [CELL_W-1:0]          seen_rd_addr;
   logic                       seen_rd;

   logic [DIM_W-1:0]           eff_rows, eff_cols;
   logic                       req_inr, e_inr, e_valid, scan_done, fill_done;
   logic [CELL_W-1:0]          e_cell, f_cell;
   logic [2*DIM_W-1:0]         area;
   logic [TOT_W-1:0]           total;
   logic                       fp_at_end;

   function automatic logic in_range(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
                                     input logic [DIM_W-1:0] nr, input logic [DIM_W-1:0] nc);
      in_range = (r != '0) && (r <= nr) && (c != '0) && (c <= nc);
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      clamp_dim = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
   endfunction

   sms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   sms_ram #(
      .WIDTH (1),
      .DEPTH (MAX_DIM * MAX_DIM)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (seen_wr_addr),
      .wr_data (seen_wr_data),
      .rd_addr (seen_rd_addr),
      .rd_data (seen_rd)
   );

   assign e_entry  = entry_type'(ram_rd_raw);
   assign eff_rows = clamp_dim(swapped_ff ? col_count_ff : row_count_ff);
   assign eff_cols = clamp_dim(swapped_ff ? row_count_ff : col_count_ff);
   assign req_inr  = in_range(req_ch.row, req_ch.col, eff_rows, eff_cols);
   assign e_inr    = in_range(e_entry.row, e_entry.col, eff_rows, eff_cols);
   assign e_valid  = valid_ff[eval_idx_ff];
   assign e_cell   = CELL_W'((e_entry.row - 1'b1) * MAX_DIM + (e_entry.col - 1'b1));
   assign f_cell   = CELL_W'(ci_ff * MAX_DIM + cj_ff);
   assign area     = eff_rows * eff_cols;
   assign total    = TOT_W'(count_ff) + TOT_W'(area) - TOT_W'(present_ff) - TOT_W'(dels_ff);
   assign scan_done = (idx_ff == CNT_W'(CAPACITY)) && !eval_vld_ff;
   assign fill_done = (ci_ff >= eff_rows) || (eff_cols == '0);
   assign fp_at_end = (fp_ff == CNT_W'(CAPACITY));

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = (state_ff == ST_RESP);
   assign rsp_ch.read_value   = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.stored_count = count_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pass_b_in     = pass_b_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      v_in          = v_ff;
      idx_in        = idx_ff;
      eval_vld_in   = 1'b0;
      eval_idx_in   = eval_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      default_in    = default_ff;
      swapped_in    = swapped_ff;
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      any_in        = any_ff;
      present_in    = present_ff;
      dels_in       = dels_ff;
      ci_in         = ci_ff;
      cj_in         = cj_ff;
      fp_in         = fp_ff;
      fphase_in     = fphase_ff;
      clr_in        = clr_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = eval_idx_ff;
      ram_wr_data   = e_entry;
      ram_rd_addr   = idx_ff[SLOT_W-1:0];
      seen_wr_en    = 1'b0;
      seen_wr_addr  = e_cell;
      seen_wr_data  = 1'b1;
      seen_rd_addr  = f_cell;

      // the user issues configuration writes only while nothing is in flight, unchecked
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wr_data;
            CSR_COL_COUNT: col_count_in = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            // wipe the cell marks once after reset
            seen_wr_en   = 1'b1;
            seen_wr_addr = clr_ff;
            seen_wr_data = 1'b0;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_ch.valid) begin
               // capture the item and arm the table walk
               op_in         = req_ch.cmd;
               r_in          = req_ch.row;
               c_in          = req_ch.col;
               v_in          = req_ch.value;
               pass_b_in     = 1'b0;
               idx_in        = '0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               any_in        = 1'b0;
               present_in    = '0;
               dels_in       = '0;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_OK;
               state_in      = ST_SCAN;
               case (req_ch.cmd)
                  CMD_WRITE: begin
                     if (!req_inr) begin
                        rsp_status_in = STATUS_OOR;
                        state_in      = ST_RESP;
                     end
                  end
                  CMD_READ: begin
                     if (!req_inr) begin
                        rsp_value_in  = default_ff;
                        rsp_status_in = STATUS_OOR;
                        state_in      = ST_RESP;
                     end
                  end
                  CMD_SET_DEF: begin
                     if (req_ch.value == default_ff) begin
                        state_in = ST_RESP;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            // issue the next slot read; its data is judged in the following cycle
            if (idx_ff != CNT_W'(CAPACITY)) begin
               eval_vld_in = 1'b1;
               eval_idx_in = idx_ff[SLOT_W-1:0];
               idx_in      = idx_ff + 1'b1;
            end

            if (eval_vld_ff) begin
               case (op_ff)
                  CMD_WRITE, CMD_READ: begin
                     if (e_valid && (e_entry.row == r_ff) && (e_entry.col == c_ff)) begin
                        hit_in     = 1'b1;
                        hit_idx_in = eval_idx_ff;
                        hit_val_in = e_entry.value;
                     end
                     if (!e_valid && !free_ff) begin
                        free_in     = 1'b1;
                        free_idx_in = eval_idx_ff;
                     end
                  end
                  CMD_SET_DEF: begin
                     if (!pass_b_ff) begin
                        if (e_valid && (e_entry.value == v_ff)) begin
                           any_in = 1'b1;
                        end
                        if (e_valid && e_inr) begin
                           present_in = present_ff + 1'b1;
                           if (e_entry.value == v_ff) begin
                              dels_in = dels_ff + 1'b1;
                           end
                        end
                     end else if (e_valid && e_inr) begin
                        // mark the cell occupied, drop entries equal to the new default
                        seen_wr_en = 1'b1;
                        if (e_entry.value == v_ff) begin
                           valid_in[eval_idx_ff] = 1'b0;
                           count_in              = count_ff - 1'b1;
                        end
                     end
                  end
                  CMD_TRANSPOSE: begin
                     if (e_valid) begin
                        if (e_inr) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_data = '{row: e_entry.col, col: e_entry.row,
                                           value: e_entry.value};
                        end else begin
                           valid_in[eval_idx_ff] = 1'b0;
                           count_in              = count_ff - 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end

            if (scan_done) begin
               state_in = ST_RESP;
               case (op_ff)
                  CMD_WRITE: begin
                     if (hit_ff) begin
                        if (v_ff == default_ff) begin
                           valid_in[hit_idx_ff] = 1'b0;
                           count_in             = count_ff - 1'b1;
                        end else begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = hit_idx_ff;
                           ram_wr_data = '{row: r_ff, col: c_ff, value: v_ff};
                        end
                     end else if (v_ff != default_ff) begin
                        if (free_ff) begin
                           ram_wr_en             = 1'b1;
                           ram_wr_addr           = free_idx_ff;
                           ram_wr_data           = '{row: r_ff, col: c_ff, value: v_ff};
                           valid_in[free_idx_ff] = 1'b1;
                           count_in              = count_ff + 1'b1;
                        end else begin
                           rsp_status_in = STATUS_FULL;
                        end
                     end
                  end
                  CMD_READ: begin
                     rsp_value_in = hit_ff ? hit_val_ff : default_ff;
                  end
                  CMD_SET_DEF: begin
                     if (!pass_b_ff) begin
                        if (!any_ff) begin
                           default_in = v_ff;
                        end else if (total > TOT_W'(CAPACITY)) begin
                           rsp_status_in = STATUS_FULL;
                        end else begin
                           // second walk: delete and mark occupied cells
                           pass_b_in = 1'b1;
                           idx_in    = '0;
                           state_in  = ST_SCAN;
                        end
                     end else begin
                        ci_in     = '0;
                        cj_in     = '0;
                        fp_in     = '0;
                        fphase_in = 1'b0;
                        state_in  = ST_FILL;
                     end
                  end
                  CMD_TRANSPOSE: begin
                     swapped_in = !swapped_ff;
                  end
                  default: ;
               endcase
            end
         end

         ST_FILL: begin
            // store every unmarked cell with the old default in the lowest free slot;
            // the first phase of a cell reads its mark, the second acts on it
            if (fill_done) begin
               default_in = v_ff;
               state_in   = ST_RESP;
            end else if (!fphase_ff) begin
               fphase_in = 1'b1;
            end else if (!seen_rd && !fp_at_end && valid_ff[fp_ff[SLOT_W-1:0]]) begin
               fp_in = fp_ff + 1'b1;
            end else begin
               if (!seen_rd && !fp_at_end) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = fp_ff[SLOT_W-1:0];
                  ram_wr_data = '{row: ci_ff + 1'b1, col: cj_ff + 1'b1, value: default_ff};
                  valid_in[fp_ff[SLOT_W-1:0]] = 1'b1;
                  count_in    = count_ff + 1'b1;
                  fp_in       = fp_ff + 1'b1;
               end
               // drop the mark so the map is empty for the next default change
               seen_wr_en   = 1'b1;
               seen_wr_addr = f_cell;
               seen_wr_data = 1'b0;
               fphase_in    = 1'b0;
               if (cj_ff + 1'b1 == eff_cols) begin
                  cj_in = '0;
                  ci_in = ci_ff + 1'b1;
               end else begin
                  cj_in = cj_ff + 1'b1;
               end
            end
         end

         ST_RESP: begin
            // hold the item until the sink takes it
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         eval_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         default_ff   <= '0;
         swapped_ff   <= 1'b0;
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         eval_vld_ff  <= eval_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         default_ff   <= default_in;
         swapped_ff   <= swapped_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pass_b_ff     <= pass_b_in;
      r_ff          <= r_in;
      c_ff          <= c_in;
      v_ff          <= v_in;
      idx_ff        <= idx_in;
      eval_idx_ff   <= eval_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_val_ff    <= hit_val_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      any_ff        <= any_in;
      present_ff    <= present_in;
      dels_ff       <= dels_in;
      ci_ff         <= ci_in;
      cj_ff         <= cj_in;
      fp_ff         <= fp_in;
      fphase_ff     <= fphase_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // the running count always matches the live slots
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("stored count differs from live slot total");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count above capacity");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("new item taken before the previous one was answered");

   a_fill_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && ram_wr_en) |-> !fp_at_end)
      else $error("fill write past the last slot");
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import sms_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int ITEMS_PER_SET = 60;
   localparam int LONG_HOLD     = 700;
   localparam int STALL_LIMIT   = 6000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int NUM_SETS      = 10;

   // Model of the sparse matrix, answer queue and result comparison.
   class sparse_matrix_board;
      typedef struct {
         logic [VAL_W-1:0]  read_value;
         logic [STAT_W-1:0] status;
         logic [CNT_W-1:0]  stored_count;
      } answer_t;

      bit               slot_used[CAPACITY];
      logic [DIM_W-1:0] slot_r[CAPACITY];
      logic [DIM_W-1:0] slot_c[CAPACITY];
      logic [VAL_W-1:0] slot_v[CAPACITY];
      int               n_entries;
      logic [VAL_W-1:0] dflt;
      bit               swapped;
      logic [DIM_W-1:0] rows_reg;
      logic [DIM_W-1:0] cols_reg;
      answer_t          answers[$];
      int               mismatches;
      int               cmd_seen[4];
      int               status_seen[4];

      function void set_dims(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
         rows_reg = rows;
         cols_reg = cols;
      endfunction

      function int clamp(logic [DIM_W-1:0] d);
         return (d > MAX_DIM) ? MAX_DIM : int'(d);
      endfunction

      function int eff_rows();
         return clamp(swapped ? cols_reg : rows_reg);
      endfunction

      function int eff_cols();
         return clamp(swapped ? rows_reg : cols_reg);
      endfunction

      function bit in_range(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
         return r >= 1 && r <= eff_rows() && c >= 1 && c <= eff_cols();
      endfunction

      function int find_slot(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
         for (int k = 0; k < CAPACITY; k++)
            if (slot_used[k] && slot_r[k] == r && slot_c[k] == c) return k;
         return -1;
      endfunction

      function int free_slot();
         for (int k = 0; k < CAPACITY; k++)
            if (!slot_used[k]) return k;
         return -1;
      endfunction

      function void recount();
         n_entries = 0;
         foreach (slot_used[k]) if (slot_used[k]) n_entries++;
      endfunction

      function logic [STAT_W-1:0] write_cell(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c,
                                             logic [VAL_W-1:0] v);
         int k;
         if (!in_range(r, c)) return STATUS_OOR;
         k = find_slot(r, c);
         if (k < 0) begin
            // writing the default into an absent cell is a no-op
            if (v == dflt) return STATUS_OK;
            k = free_slot();
            if (k < 0) return STATUS_FULL;
            slot_used[k] = 1;
            slot_r[k] = r;
            slot_c[k] = c;
            slot_v[k] = v;
            n_entries++;
         end else if (v == dflt) begin
            slot_used[k] = 0;
            n_entries--;
         end else begin
            slot_v[k] = v;
         end
         return STATUS_OK;
      endfunction

      function logic [STAT_W-1:0] change_default(logic [VAL_W-1:0] v);
         int rows, cols, dels, present, k;
         bit any;
         bit seen[MAX_DIM][MAX_DIM];
         rows = eff_rows();
         cols = eff_cols();
         dels = 0;
         present = 0;
         any = 0;
         foreach (slot_used[i]) if (slot_used[i] && slot_v[i] == v) any = 1;
         if (v == dflt || !any) begin
            dflt = v;
            return STATUS_OK;
         end
         foreach (slot_used[i])
            if (slot_used[i] && in_range(slot_r[i], slot_c[i])) begin
               present++;
               if (slot_v[i] == v) dels++;
            end
         if (n_entries - dels + rows * cols - present > CAPACITY) return STATUS_FULL;
         foreach (seen[i, j]) seen[i][j] = 0;
         foreach (slot_used[i])
            if (slot_used[i] && in_range(slot_r[i], slot_c[i])) begin
               seen[slot_r[i] - 1][slot_c[i] - 1] = 1;
               if (slot_v[i] == v) slot_used[i] = 0;
            end
         // materialize every absent in-range cell with the old default
         for (int i = 1; i <= rows; i++)
            for (int j = 1; j <= cols; j++)
               if (!seen[i - 1][j - 1]) begin
                  k = free_slot();
                  if (k >= 0) begin
                     slot_used[k] = 1;
                     slot_r[k] = DIM_W'(i);
                     slot_c[k] = DIM_W'(j);
                     slot_v[k] = dflt;
                  end
               end
         dflt = v;
         recount();
         return STATUS_OK;
      endfunction

      function void transpose_cells();
         logic [DIM_W-1:0] t;
         foreach (slot_used[k]) begin
            if (!slot_used[k]) continue;
            if (in_range(slot_r[k], slot_c[k])) begin
               t = slot_r[k];
               slot_r[k] = slot_c[k];
               slot_c[k] = t;
            end else begin
               slot_used[k] = 0;
            end
         end
         swapped = !swapped;
         recount();
      endfunction

      // Note an accepted command and queue the answer it must produce.
      function void note_command(logic [CMD_W-1:0] cmd, logic [DIM_W-1:0] r,
                                 logic [DIM_W-1:0] c, logic [VAL_W-1:0] v);
         answer_t a;
         int k;
         a.read_value = '0;
         a.status = STATUS_OK;
         case (cmd)
            CMD_WRITE: a.status = write_cell(r, c, v);
            CMD_READ: begin
               a.read_value = dflt;
               if (!in_range(r, c)) begin
                  a.status = STATUS_OOR;
               end else begin
                  k = find_slot(r, c);
                  if (k >= 0) a.read_value = slot_v[k];
               end
            end
            CMD_SET_DEF: a.status = change_default(v);
            default: transpose_cells();
         endcase
         a.stored_count = CNT_W'(n_entries);
         cmd_seen[cmd]++;
         status_seen[a.status]++;
         answers.push_back(a);
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
      endfunction

      // Compare one accepted answer with the oldest one waiting.
      function void check_answer(logic [VAL_W-1:0] rd, logic [STAT_W-1:0] st,
                                 logic [CNT_W-1:0] cnt);
         answer_t a;
         if (answers.size() == 0) begin
            report($sformatf("unexpected item rd=%h st=%0d cnt=%0d", rd, st, cnt));
            return;
         end
         a = answers.pop_front();
         if (rd !== a.read_value)
            report($sformatf("read_value exp %h got %h", a.read_value, rd));
         if (st !== a.status)
            report($sformatf("status exp %0d got %0d", a.status, st));
         if (cnt !== a.stored_count)
            report($sformatf("stored_count exp %0d got %0d", a.stored_count, cnt));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic csr_index = CSR_ROW_COUNT;
   logic [DIM_W-1:0] csr_wr_data = '0;

   sms_req_if req_ch ();
   sms_rsp_if rsp_ch ();

   sparse_matrix_store u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   sparse_matrix_board board = new();

   bit offering = 0;     // req valid currently held high
   bit quiet = 0;        // no idling on either side
   bit hold_request = 0; // ask the receiver for one long hold-off
   int idle_cycles = 0;

   always #HALF_PERIOD clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.cmd = CMD_READ;
      req_ch.row = '0;
      req_ch.col = '0;
      req_ch.value = '0;
      rsp_ch.ready = 0;
   end

   // Receiver: check accepted items, then pick the next ready level.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_answer(rsp_ch.read_value, rsp_ch.status, rsp_ch.stored_count);
         if (hold_request) begin
            hold_request = 0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 0;
         end else if (quiet || $urandom_range(0, 9) < 7) begin
            rsp_ch.ready <= 1;
         end else begin
            stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
            rsp_ch.ready <= 0;
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic int sender_gap();
      int pick;
      if (quiet) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 10) return 0;
      if (pick < 17) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one command and hold it until the block takes it.
   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [DIM_W-1:0] r,
                           logic [DIM_W-1:0] c, logic [VAL_W-1:0] v);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         if (offering) req_ch.valid <= 0;
         offering = 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.cmd <= cmd;
      req_ch.row <= r;
      req_ch.col <= c;
      req_ch.value <= v;
      offering = 1;
      do @(posedge clock); while (!req_ch.ready);
      board.note_command(cmd, r, c, v);
   endtask

   // Drop valid in the step of the last accept.
   task automatic rest_sender();
      if (offering) req_ch.valid <= 0;
      offering = 0;
   endtask

   task automatic wait_drained();
      rest_sender();
      while (board.answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both dimension registers while the block is idle.
   task automatic apply_dims(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
      wait_drained();
      csr_wr_en <= 1;
      csr_index <= CSR_ROW_COUNT;
      csr_wr_data <= rows;
      @(posedge clock);
      csr_index <= CSR_COL_COUNT;
      csr_wr_data <= cols;
      @(posedge clock);
      csr_wr_en <= 0;
      board.set_dims(rows, cols);
      @(posedge clock);
   endtask

   // Values come mostly from a small pool so defaults collide with entries.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return board.dflt;
         4, 5, 6: return $urandom_range(0, 3);
         7: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_index(int dim);
      if ($urandom_range(0, 9) == 0) return DIM_W'($urandom_range(0, 31));
      return DIM_W'($urandom_range(1, dim + 1));
   endfunction

   task automatic random_cmd();
      int pick;
      logic [CMD_W-1:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 50) cmd = CMD_WRITE;
      else if (pick < 80) cmd = CMD_READ;
      else if (pick < 93) cmd = CMD_SET_DEF;
      else cmd = CMD_TRANSPOSE;
      send_cmd(cmd, pick_index(board.eff_rows()), pick_index(board.eff_cols()),
               pick_value());
   endtask

   task automatic directed_cmds(int set);
      case (set)
         0: begin
            // 3 x 2 matrix: extremes, range errors, updates and deletes
            send_cmd(CMD_WRITE, 1, 1, 32'h8000_0000);
            send_cmd(CMD_WRITE, 3, 2, 32'h7FFF_FFFF);
            send_cmd(CMD_WRITE, 0, 1, 5);
            send_cmd(CMD_WRITE, 4, 1, 5);
            send_cmd(CMD_WRITE, 1, 3, 5);
            send_cmd(CMD_WRITE, 31, 31, 5);
            send_cmd(CMD_WRITE, 2, 2, 0);
            send_cmd(CMD_READ, 1, 1, 0);
            send_cmd(CMD_READ, 2, 1, 0);
            send_cmd(CMD_READ, 0, 0, 0);
            send_cmd(CMD_WRITE, 1, 1, 9);
            send_cmd(CMD_WRITE, 1, 1, 0);
            send_cmd(CMD_SET_DEF, 0, 0, 0);
            send_cmd(CMD_SET_DEF, 31, 31, 5);
            send_cmd(CMD_READ, 2, 2, 0);
            send_cmd(CMD_SET_DEF, 0, 0, 32'h7FFF_FFFF);
            send_cmd(CMD_READ, 3, 2, 0);
            send_cmd(CMD_READ, 1, 2, 0);
            send_cmd(CMD_TRANSPOSE, 0, 0, 0);
            send_cmd(CMD_READ, 2, 3, 0);
            send_cmd(CMD_WRITE, 2, 3, 1);
            send_cmd(CMD_WRITE, 3, 2, 1);
         end
         1: begin
            // 8 x 8: one default change fills the table, one write tops it off
            send_cmd(CMD_WRITE, 1, 1, 3);
            send_cmd(CMD_SET_DEF, 0, 0, 3);
            send_cmd(CMD_WRITE, 1, 1, 7);
         end
         2: begin
            // 16 x 16 with a full table
            send_cmd(CMD_WRITE, 9, 9, 7);
            send_cmd(CMD_SET_DEF, 0, 0, 7);
         end
         default: ;
      endcase
   endtask

   initial begin : stimulus
      logic [DIM_W-1:0] set_rows[NUM_SETS] = '{3, 8, 16, 4, 0, 31, 2, 1, 16, 5};
      logic [DIM_W-1:0] set_cols[NUM_SETS] = '{2, 8, 16, 4, 5, 2, 3, 1, 1, 6};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int s = 0; s < NUM_SETS; s++) begin
         quiet = (s % 4 == 3);
         apply_dims(set_rows[s], set_cols[s]);
         directed_cmds(s);
         if (s == 4) begin
            // hold the result side long while items keep being offered
            hold_request = 1;
            for (int i = 0; i < 5; i++) random_cmd();
            // pause the sender until every answer is back
            wait_drained();
         end
         for (int i = 0; i < ITEMS_PER_SET; i++) random_cmd();
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d writes, %0d reads, %0d default changes, %0d transposes",
               board.cmd_seen[CMD_WRITE], board.cmd_seen[CMD_READ],
               board.cmd_seen[CMD_SET_DEF], board.cmd_seen[CMD_TRANSPOSE]);
      $display("status ok %0d, out of range %0d, table full %0d; %0d mismatches",
               board.status_seen[STATUS_OK], board.status_seen[STATUS_OOR],
               board.status_seen[STATUS_FULL], board.mismatches);
      if (board.mismatches == 0 && board.answers.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
